// ===== rtl/tli_pkg.sv =====
package tli_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int COUNT_W = 9;
  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_DROP,
    KIND_EMPTY,
    KIND_QUERY
  } kind_t;

  typedef enum logic [1:0] {
    REGION_EMPTY  = 2'd0,
    REGION_LOW    = 2'd1,
    REGION_HIGH   = 2'd2,
    REGION_INTERP = 2'd3
  } region_t;

  typedef struct packed {
    kind_t                    kind;
    logic [ADDR_W-1:0]        index;
    logic [ADDR_W-1:0]        last;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
  } req_t;

endpackage

// ===== rtl/tli_front.sv =====
module tli_front
  import tli_pkg::*;
(
  input  logic                     req_valid,
  output logic                     req_stall,
  input  logic                     func,
  input  logic [7:0]               entry_index,
  input  logic signed [DATA_W-1:0] entry_x,
  input  logic signed [DATA_W-1:0] entry_y,
  input  logic signed [DATA_W-1:0] query_x,
  input  logic [COUNT_W-1:0]       entry_count,
  input  logic                     full,
  output logic                     push,
  output req_t                     push_data
);

  logic [COUNT_W-1:0] n_sat;
  logic               slot_ok;

  always_comb begin
    if (entry_count > COUNT_W'(TABLE_DEPTH)) begin
      n_sat = COUNT_W'(TABLE_DEPTH);
    end else begin
      n_sat = entry_count;
    end
    slot_ok = COUNT_W'(entry_index) < COUNT_W'(TABLE_DEPTH);

    push_data.index = ADDR_W'(entry_index);
    push_data.last  = ADDR_W'(n_sat - COUNT_W'(1));
    if (func_t'(func) == FUNC_WRITE) begin
      push_data.kind = slot_ok ? KIND_WRITE : KIND_DROP;
      push_data.x    = entry_x;
      push_data.y    = entry_y;
    end else begin
      push_data.kind = (n_sat == '0) ? KIND_EMPTY : KIND_QUERY;
      push_data.x    = query_x;
      push_data.y    = '0;
    end
  end

  assign req_stall = full;
  assign push      = req_valid && !full;

endmodule

// ===== rtl/tli_queue.sv =====
module tli_queue
  import tli_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t push_data,
  output logic full,
  input  logic pop,
  output req_t pop_data,
  output logic empty
);

  req_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

// ===== rtl/tli_engine.sv =====
module tli_engine
  import tli_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     empty,
  input  req_t                     pop_data,
  output logic                     pop,
  output logic                     res_valid,
  input  logic                     res_stall,
  output logic signed [DATA_W-1:0] value,
  output logic [1:0]               region
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_SEARCH,
    S_PREP,
    S_DIV,
    S_MUL,
    S_DONE
  } state_t;

  localparam int CNT_W = $clog2(FRAC_W);
  localparam int PROD_W = DATA_W + 1 + FRAC_W + 1;

  logic [2*DATA_W-1:0]       bp_mem [TABLE_DEPTH];
  logic [2*DATA_W-1:0]       rd_data;
  logic [ADDR_W-1:0]         rd_addr;

  state_t                    state;
  logic signed [DATA_W-1:0]  xq;
  logic [ADDR_W-1:0]         last;
  logic [ADDR_W-1:0]         lo;
  logic [ADDR_W-1:0]         hi;
  logic [ADDR_W-1:0]         mid;
  logic signed [DATA_W-1:0]  xlo;
  logic signed [DATA_W-1:0]  ylo;
  logic signed [DATA_W-1:0]  xhi;
  logic signed [DATA_W-1:0]  yhi;
  logic [DATA_W-1:0]         rem;
  logic [DATA_W-1:0]         den;
  logic [FRAC_W-1:0]         quo;
  logic [CNT_W-1:0]          cnt;
  logic signed [DATA_W:0]    dy;
  logic signed [PROD_W-1:0]  prod;
  logic signed [DATA_W-1:0]  acc;
  region_t                   acc_region;
  logic signed [DATA_W-1:0]  out_value;
  region_t                   out_region;

  logic signed [DATA_W-1:0]  rd_x;
  logic signed [DATA_W-1:0]  rd_y;
  logic                      go_lo;
  logic [ADDR_W-1:0]         lo_next;
  logic [ADDR_W-1:0]         hi_next;
  logic [ADDR_W:0]           mid_sum;
  logic [ADDR_W-1:0]         mid_next;
  logic                      more;
  logic [DATA_W:0]           rem2;
  logic [DATA_W:0]           rem_sub;
  logic                      div_ge;
  logic                      free;

  assign rd_x = rd_data[2*DATA_W-1:DATA_W];
  assign rd_y = rd_data[DATA_W-1:0];
  assign pop  = (state == S_IDLE) && !empty;
  assign free = !res_valid || !res_stall;

  always_comb begin
    go_lo = (rd_x <= xq);
    case (state)
      S_LAST: begin
        lo_next = '0;
        hi_next = last;
      end
      S_SEARCH: begin
        lo_next = go_lo ? mid : lo;
        hi_next = go_lo ? hi : mid;
      end
      default: begin
        lo_next = lo;
        hi_next = hi;
      end
    endcase
    more     = (hi_next - lo_next) > ADDR_W'(1);
    mid_sum  = {1'b0, lo_next} + {1'b0, hi_next};
    mid_next = mid_sum[ADDR_W:1];
    case (state)
      S_IDLE:  rd_addr = '0;
      S_FIRST: rd_addr = last;
      default: rd_addr = mid_next;
    endcase
    rem2    = {rem, 1'b0};
    div_ge  = rem2 >= {1'b0, den};
    rem_sub = rem2 - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (pop && pop_data.kind == KIND_WRITE) begin
      bp_mem[pop_data.index] <= {pop_data.x, pop_data.y};
    end
    rd_data <= bp_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (state == S_DONE && free) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            xq   <= pop_data.x;
            last <= pop_data.last;
            case (pop_data.kind)
              KIND_QUERY: state <= S_FIRST;
              KIND_EMPTY: begin
                acc        <= '0;
                acc_region <= REGION_EMPTY;
                state      <= S_DONE;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_FIRST: begin
          xlo <= rd_x;
          ylo <= rd_y;
          acc <= rd_y;
          if (xq <= rd_x) begin
            acc_region <= REGION_LOW;
            state      <= S_DONE;
          end else if (last == '0) begin
            acc_region <= REGION_HIGH;
            state      <= S_DONE;
          end else begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          xhi <= rd_x;
          yhi <= rd_y;
          lo  <= lo_next;
          hi  <= hi_next;
          mid <= mid_next;
          if (xq >= rd_x) begin
            acc        <= rd_y;
            acc_region <= REGION_HIGH;
            state      <= S_DONE;
          end else begin
            state <= more ? S_SEARCH : S_PREP;
          end
        end
        S_SEARCH: begin
          if (go_lo) begin
            xlo <= rd_x;
            ylo <= rd_y;
          end else begin
            xhi <= rd_x;
            yhi <= rd_y;
          end
          lo    <= lo_next;
          hi    <= hi_next;
          mid   <= mid_next;
          state <= more ? S_SEARCH : S_PREP;
        end
        S_PREP: begin
          rem   <= DATA_W'(xq - xlo);
          den   <= DATA_W'(xhi - xlo);
          dy    <= {yhi[DATA_W-1], yhi} - {ylo[DATA_W-1], ylo};
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem   <= div_ge ? rem_sub[DATA_W-1:0] : rem2[DATA_W-1:0];
          quo   <= {quo[FRAC_W-2:0], div_ge};
          cnt   <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(FRAC_W - 1)) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod       <= PROD_W'(dy * $signed({1'b0, quo}));
          acc_region <= REGION_INTERP;
          state      <= S_DONE;
          acc        <= ylo;
        end
        S_DONE: begin
          if (free) begin
            if (acc_region == REGION_INTERP) begin
              out_value <= acc + DATA_W'(prod >>> FRAC_W);
            end else begin
              out_value <= acc;
            end
            out_region <= acc_region;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign value  = out_value;
  assign region = out_region;

`ifndef SYNTHESIS
  a_search_span: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> ((hi - lo) > ADDR_W'(1)))
    else $error("search window collapsed");
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < den))
    else $error("divider remainder not below divisor");
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> ($past(state) == S_DIV && cnt == '0))
    else $error("fraction divide did not run its full length");
`endif

endmodule

// ===== rtl/table_linear_interpolator_core.sv =====
// Piecewise linear interpolator over a 256-entry table of signed Q16.16 breakpoints.
// A request with func 0 stores entry_x/entry_y at entry_index and gives no result; a request
// with func 1 returns the interpolated value at query_x plus a region code (0 empty table,
// 1 clamped low, 2 clamped high, 3 interpolated). entry_count is set through cfg_wen/cfg_wdata
// while the block is idle; the user must keep to this, as the block itself does not enforce it.
// A write is stored in the table when the execution unit takes it from the queue. A query
// runs one table read per cycle on the single read port, for the first and last entries and
// the binary search, then for an interpolated result a restoring divide, multiply and output.
// A two-entry request queue lets new requests be taken while a query is in work, and the
// result register holds one finished result while the next request proceeds.
module table_linear_interpolator_core
  import tli_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wen,
  input  logic [COUNT_W-1:0]       cfg_wdata,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  logic                     func,
  input  logic [7:0]               entry_index,
  input  logic signed [DATA_W-1:0] entry_x,
  input  logic signed [DATA_W-1:0] entry_y,
  input  logic signed [DATA_W-1:0] query_x,
  output logic                     res_valid,
  input  logic                     res_stall,
  output logic signed [DATA_W-1:0] value,
  output logic [1:0]               region
);

  logic [COUNT_W-1:0] entry_count;
  logic               push;
  req_t               push_data;
  logic               full;
  logic               pop;
  req_t               pop_data;
  logic               empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_wen) begin
      entry_count <= cfg_wdata;
    end
  end

  tli_front u_front (
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .func        (func),
    .entry_index (entry_index),
    .entry_x     (entry_x),
    .entry_y     (entry_y),
    .query_x     (query_x),
    .entry_count (entry_count),
    .full        (full),
    .push        (push),
    .push_data   (push_data)
  );

  tli_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  tli_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .pop_data  (pop_data),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .value     (value),
    .region    (region)
  );

endmodule
